// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl files, included by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is low
`define ASSERT_AT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rbrn_pkg.sv =====
// ----------------------------------------------------------------------------
// rbrn_pkg
// shared types and constants of the bilinear resize / normalize core
// ----------------------------------------------------------------------------
`default_nettype none

package rbrn_pkg;

	localparam int SRC_W    = 10;
	localparam int TGT_W    = 11;
	localparam int SXY_W    = 9;
	localparam int CH_W     = 8;
	localparam int PIX_W    = 3 * CH_W;
	localparam int TXY_W    = 10;
	localparam int OFF_W    = 20;
	localparam int NORM_W   = 17;
	localparam int FRAC_W   = 16;
	localparam int COORD_W  = SRC_W + FRAC_W;

	// coordinate divider
	localparam int DIVIDEND_W = 21 + FRAC_W;
	localparam int DIVISOR_W  = TGT_W + 1;

	// shared multiplier
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// rounding and divide by 255 via reciprocal
	localparam logic [MUL_P_W-1:0] ROUND_BIAS  = MUL_P_W'(255 * 32768);
	localparam logic [MUL_B_W-1:0] RECIP_255   = MUL_B_W'(32897);
	localparam logic [MUL_B_W-1:0] CONST_255   = MUL_B_W'(255);
	localparam logic [MUL_B_W-1:0] WEIGHT_ONE  = MUL_B_W'(65536);

	localparam logic [1:0] CFG_SOURCE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SOURCE_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_TARGET_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_TARGET_HEIGHT = 2'd3;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [SXY_W-1:0] source_x;
		logic [SXY_W-1:0] source_y;
		logic [CH_W-1:0]  red_in;
		logic [CH_W-1:0]  green_in;
		logic [CH_W-1:0]  blue_in;
		logic [TXY_W-1:0] target_x;
		logic [TXY_W-1:0] target_y;
	} in_word_t;

	typedef struct packed {
		logic [OFF_W-1:0]  plane_offset;
		logic [NORM_W-1:0] red_out;
		logic [NORM_W-1:0] green_out;
		logic [NORM_W-1:0] blue_out;
	} out_word_t;

endpackage

`default_nettype wire

// ===== rtl/bilinear_resize_normalize_rgb_core.sv =====
// ----------------------------------------------------------------------------
// bilinear_resize_normalize_rgb_core
// frame store plus bilinear resampler with normalization to unsigned 1.16
// ----------------------------------------------------------------------------
// usage:
//  - input channel (in_valid / in_stall / in_data) carries one word per item;
//    cmd write stores an rgb pixel, cmd query asks for one destination pixel
//  - output channel (out_valid / out_stall / out_data) returns one word per
//    query: plane offset and the three normalized channels; writes give none
//  - config port (cfg_we / cfg_index / cfg_wdata) sets source and target
//    sizes; write it only while the core is idle
//  - write items are taken back to back while the core is idle
//  - a query runs two 37-step coordinate divisions on one
//    shared divider, four frame-store reads on its single port and 24 steps
//    of the shared multiplier
//  - one query is worked on at a time; in_stall is high until it finishes
//  - results sit in an output register; a stalled receiver holds the word
//    and the next query waits at its end until the register frees up
//  - reset empties the pipeline and loads the size registers with 512, 512,
//    320, 320; the frame store is not cleared, unwritten pixels read garbage
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bilinear_resize_normalize_rgb_core #(
	parameter int MAX_SOURCE_WIDTH  = 512,
	parameter int MAX_SOURCE_HEIGHT = 512,
	parameter int MAX_TARGET_SIDE   = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire rbrn_pkg::in_word_t         in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output rbrn_pkg::out_word_t             out_data,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [rbrn_pkg::TGT_W-1:0] cfg_wdata
);

	localparam int SW_ = rbrn_pkg::SRC_W;
	localparam int TW_ = rbrn_pkg::TGT_W;
	localparam int FW  = rbrn_pkg::FRAC_W;
	localparam int CW  = rbrn_pkg::COORD_W;
	localparam int AW_ = rbrn_pkg::MUL_A_W;
	localparam int BW_ = rbrn_pkg::MUL_B_W;
	localparam int PW  = rbrn_pkg::MUL_P_W;
	localparam int DW  = rbrn_pkg::DIVIDEND_W;
	localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_SOURCE_WIDTH);

	// size limits as seen through the register widths
	localparam logic [SW_-1:0] SW_MAX =
		(MAX_SOURCE_WIDTH > 1023) ? SW_'(1023) : SW_'(MAX_SOURCE_WIDTH);
	localparam logic [SW_-1:0] SH_MAX =
		(MAX_SOURCE_HEIGHT > 1023) ? SW_'(1023) : SW_'(MAX_SOURCE_HEIGHT);
	localparam logic [TW_-1:0] TS_MAX =
		(MAX_TARGET_SIDE > 2047) ? TW_'(2047) : TW_'(MAX_TARGET_SIDE);

	typedef enum logic [3:0] {
		S_IDLE, S_NX, S_DX, S_NY, S_DY, S_OFF, S_RD, S_MUL, S_DONE
	} state_t;

	// size registers
	logic [SW_-1:0] src_w_q, src_h_q;
	logic [TW_-1:0] tgt_w_q, tgt_h_q;
	logic [SW_-1:0] sw, sh;
	logic [TW_-1:0] tw, th;

	state_t state_q;
	logic [rbrn_pkg::TXY_W-1:0] tx_q, ty_q;
	logic [SW_-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [FW-1:0]  wx_q, wy_q;
	logic [2:0]     rd_cnt_q;
	logic [2:0]     step_q;
	logic [1:0]     ch_q;
	logic [rbrn_pkg::PIX_W-1:0] pix_q [4];
	logic [PW-1:0]  acc_q;
	logic [23:0]    top_q, bot_q;
	logic [23:0]    t_q;
	logic [rbrn_pkg::NORM_W-1:0] q0_q;
	logic [rbrn_pkg::NORM_W-1:0] res_q [3];
	logic [rbrn_pkg::OFF_W-1:0]  off_q;
	logic           out_valid_q;
	rbrn_pkg::out_word_t out_q;

	// shared multiplier
	logic [AW_-1:0] mul_a;
	logic [BW_-1:0] mul_b;
	logic [PW-1:0]  prod;

	// coordinate mapping
	logic [TW_-1:0] dst;
	logic [SW_-1:0] src;
	logic signed [22:0] num;
	logic [DW-1:0]  dividend;
	logic           div_start, div_busy;
	logic [DW-1:0]  quo;
	logic [CW-1:0]  coord_top, coord;
	logic [SW_-1:0] c0, c1;
	logic [SW_:0]   c0_inc;

	// frame store
	logic                       st_we;
	logic [ADDR_W-1:0]          st_addr;
	logic [rbrn_pkg::PIX_W-1:0] st_rdata;
	logic [SW_-1:0]             rd_x, rd_y;
	logic                       wr_inside;

	// interpolation operands
	logic [7:0]     p00, p01, p10, p11;
	logic [BW_-1:0] iwx, iwy;
	logic [PW-1:0]  sum;
	logic [PW-1:0]  biased;

	// ------------------------------------------------------------------
	// config
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SW_'(512);
			src_h_q <= SW_'(512);
			tgt_w_q <= TW_'(320);
			tgt_h_q <= TW_'(320);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rbrn_pkg::CFG_SOURCE_WIDTH:  src_w_q <= cfg_wdata[SW_-1:0];
				rbrn_pkg::CFG_SOURCE_HEIGHT: src_h_q <= cfg_wdata[SW_-1:0];
				rbrn_pkg::CFG_TARGET_WIDTH:  tgt_w_q <= cfg_wdata;
				rbrn_pkg::CFG_TARGET_HEIGHT: tgt_h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// zero raises to one, oversize saturates
	assign sw = (src_w_q == '0) ? SW_'(1) : (src_w_q > SW_MAX) ? SW_MAX : src_w_q;
	assign sh = (src_h_q == '0) ? SW_'(1) : (src_h_q > SH_MAX) ? SH_MAX : src_h_q;
	assign tw = (tgt_w_q == '0) ? TW_'(1) : (tgt_w_q > TS_MAX) ? TS_MAX : tgt_w_q;
	assign th = (tgt_h_q == '0) ? TW_'(1) : (tgt_h_q > TS_MAX) ? TS_MAX : tgt_h_q;

	// ------------------------------------------------------------------
	// multiplier operand select
	// ------------------------------------------------------------------
	assign p00 = pix_q[0][8*ch_q +: 8];
	assign p01 = pix_q[1][8*ch_q +: 8];
	assign p10 = pix_q[2][8*ch_q +: 8];
	assign p11 = pix_q[3][8*ch_q +: 8];
	assign iwx = rbrn_pkg::WEIGHT_ONE - {1'b0, wx_q};
	assign iwy = rbrn_pkg::WEIGHT_ONE - {1'b0, wy_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_NX: begin
				mul_a = AW_'({tx_q, 1'b1});
				mul_b = BW_'(sw);
			end
			S_NY: begin
				mul_a = AW_'({ty_q, 1'b1});
				mul_b = BW_'(sh);
			end
			S_OFF: begin
				mul_a = AW_'(ty_q);
				mul_b = BW_'(tw);
			end
			S_MUL: begin
				unique case (step_q)
					3'd0: begin mul_a = AW_'(p00);  mul_b = iwx; end
					3'd1: begin mul_a = AW_'(p01);  mul_b = BW_'(wx_q); end
					3'd2: begin mul_a = AW_'(p10);  mul_b = iwx; end
					3'd3: begin mul_a = AW_'(p11);  mul_b = BW_'(wx_q); end
					3'd4: begin mul_a = AW_'(top_q); mul_b = iwy; end
					3'd5: begin mul_a = AW_'(bot_q); mul_b = BW_'(wy_q); end
					3'd6: begin mul_a = AW_'(t_q);  mul_b = rbrn_pkg::RECIP_255; end
					3'd7: begin mul_a = AW_'(q0_q); mul_b = rbrn_pkg::CONST_255; end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign prod   = PW'(mul_a) * PW'(mul_b);
	assign sum    = acc_q + prod;
	assign biased = sum + rbrn_pkg::ROUND_BIAS;

	// ------------------------------------------------------------------
	// coordinate: ((2d+1)*src - dst) << 16 / (2*dst), clamped
	// ------------------------------------------------------------------
	assign dst = (state_q == S_NY || state_q == S_DY) ? th : tw;
	assign src = (state_q == S_NY || state_q == S_DY) ? sh : sw;
	assign num = $signed({1'b0, prod[21:0]}) - $signed({12'b0, dst});
	assign dividend  = (num > 0) ? {num[20:0], {FW{1'b0}}} : '0;
	assign div_start = (state_q == S_NX) || (state_q == S_NY);

	rbrn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  ({dst, 1'b0}),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign coord_top = {src - 1'b1, {FW{1'b0}}};
	assign coord     = (quo > DW'(coord_top)) ? coord_top : quo[CW-1:0];
	assign c0        = coord[CW-1:FW];
	assign c0_inc    = {1'b0, c0} + 1'b1;
	assign c1        = (c0_inc < {1'b0, src}) ? c0_inc[SW_-1:0] : src - 1'b1;

	// ------------------------------------------------------------------
	// frame store port: writes in idle, neighbor reads in S_RD
	// ------------------------------------------------------------------
	assign wr_inside = (int'(in_data.source_x) < MAX_SOURCE_WIDTH) &&
	                   (int'(in_data.source_y) < MAX_SOURCE_HEIGHT);
	assign st_we = (state_q == S_IDLE) && in_valid &&
	               (in_data.cmd == rbrn_pkg::CMD_WRITE) && wr_inside;

	assign rd_x = rd_cnt_q[0] ? x1_q : x0_q;
	assign rd_y = rd_cnt_q[1] ? y1_q : y0_q;

	always_comb begin
		if (state_q == S_IDLE) begin
			st_addr = ADDR_W'(in_data.source_y) * ROW_STRIDE + ADDR_W'(in_data.source_x);
		end else begin
			st_addr = ADDR_W'(rd_y) * ROW_STRIDE + ADDR_W'(rd_x);
		end
	end

	rbrn_store #(
		.DEPTH (DEPTH),
		.AW    (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.addr  (st_addr),
		.wdata ({in_data.blue_in, in_data.green_in, in_data.red_in}),
		.rdata (st_rdata)
	);

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			rd_cnt_q    <= '0;
			step_q      <= '0;
			ch_q        <= '0;
		end else begin
			// receiver took the word; in S_DONE the reload below decides
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_data.cmd == rbrn_pkg::CMD_QUERY) begin
						tx_q    <= in_data.target_x;
						ty_q    <= in_data.target_y;
						state_q <= S_NX;
					end
				end
				S_NX: state_q <= S_DX;
				S_DX: begin
					if (!div_busy) begin
						x0_q    <= c0;
						x1_q    <= c1;
						wx_q    <= coord[FW-1:0];
						state_q <= S_NY;
					end
				end
				S_NY: state_q <= S_DY;
				S_DY: begin
					if (!div_busy) begin
						y0_q    <= c0;
						y1_q    <= c1;
						wy_q    <= coord[FW-1:0];
						state_q <= S_OFF;
					end
				end
				S_OFF: begin
					// row times target width plus column
					off_q    <= prod[rbrn_pkg::OFF_W-1:0] + rbrn_pkg::OFF_W'(tx_q);
					rd_cnt_q <= '0;
					state_q  <= S_RD;
				end
				S_RD: begin
					// read data arrives in the cycle after its address
					if (rd_cnt_q != '0) begin
						pix_q[2'(rd_cnt_q - 1'b1)] <= st_rdata;
					end
					if (rd_cnt_q == 3'd4) begin
						step_q  <= '0;
						ch_q    <= '0;
						state_q <= S_MUL;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					unique case (step_q)
						3'd0, 3'd2, 3'd4: acc_q <= prod;
						3'd1: top_q <= sum[23:0];
						3'd3: bot_q <= sum[23:0];
						3'd5: t_q   <= biased[39:16];
						3'd6: q0_q  <= prod[39:23];
						3'd7: begin
							// reciprocal may overshoot by one
							res_q[ch_q] <= (prod > PW'(t_q)) ? q0_q - 1'b1 : q0_q;
							if (ch_q == 2'd2) begin
								state_q <= S_DONE;
							end else begin
								ch_q <= ch_q + 1'b1;
							end
						end
						default: ;
					endcase
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q        <= 1'b1;
						out_q.plane_offset <= off_q;
						out_q.red_out      <= res_q[0];
						out_q.green_out    <= res_q[1];
						out_q.blue_out     <= res_q[2];
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`ASSERT_AT_CLK(a_div_only_waiting, div_busy |-> (state_q == S_DX || state_q == S_DY), "divider busy outside a coordinate wait")
	`ASSERT_AT_CLK(a_cols_in_frame, (state_q == S_RD) |-> (x1_q < sw && x0_q <= x1_q && y1_q < sh), "neighbor outside source frame")
	`ASSERT_AT_CLK(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result word without finished query")
	`ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (state_q == S_IDLE && !out_valid_q), "not idle in reset")

endmodule

`default_nettype wire

// ===== rtl/rbrn_div.sv =====
// ----------------------------------------------------------------------------
// rbrn_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rbrn_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [rbrn_pkg::DIVIDEND_W-1:0]     dividend,
	input  wire logic [rbrn_pkg::DIVISOR_W-1:0]      divisor,
	output logic                                     busy,
	output logic [rbrn_pkg::DIVIDEND_W-1:0]          quotient
);

	localparam int DW  = rbrn_pkg::DIVIDEND_W;
	localparam int VW  = rbrn_pkg::DIVISOR_W;
	localparam int CW  = $clog2(DW);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [VW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(shifted - {1'b0, dvs_q}) : VW'(shifted);
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/rbrn_store.sv =====
// ----------------------------------------------------------------------------
// rbrn_store
// single-port frame store with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rbrn_store #(
	parameter int DEPTH = 262144,
	parameter int AW    = 18
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               addr,
	input  wire logic [rbrn_pkg::PIX_W-1:0]  wdata,
	output logic [rbrn_pkg::PIX_W-1:0]       rdata
);

	logic [rbrn_pkg::PIX_W-1:0] mem [DEPTH];
	logic [rbrn_pkg::PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
